### src/counting_semaphore_pool_unit_macros.svh
// ----------------------------------------------------------------------------
// counting_semaphore_pool_unit_macros
// Assertion helpers used by the checker file of the semaphore pool.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_POOL_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_POOL_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants of the counting semaphore pool.
// ----------------------------------------------------------------------------
package csp_pkg;

  // request opcodes
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_WAIT   = 2'd2,
    OP_SIGNAL = 2'd3
  } op_t;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // semaphore count limits (16-bit two's complement)
  localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

  // classified request, front to back
  typedef struct packed {
    op_t         op;
    logic [3:0]  sem_id;
    logic        sid_ok;
    logic [14:0] start_count;
    logic [5:0]  pid;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       status;
    logic [3:0] new_id;
    logic       blocked;
    logic       woken_valid;
    logic [5:0] woken_id;
  } res_t;

endpackage

### src/csp_fifo.sv
// ----------------------------------------------------------------------------
// csp_fifo
// Small register FIFO used between the pipeline parts of the semaphore pool.
// ----------------------------------------------------------------------------
module csp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

### src/csp_front.sv
// ----------------------------------------------------------------------------
// csp_front
// Accepts requests, classifies them and holds them for the executor.
// ----------------------------------------------------------------------------
module csp_front #(
  parameter int NUM_SEMS  = 16,
  parameter int MAX_PROCS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        op,
  input  logic [3:0]        sem_id,
  input  logic [14:0]       start_count,
  input  logic [5:0]        requester_id,
  input  logic              cmd_pop,
  output logic              cmd_valid,
  output csp_pkg::cmd_t     cmd
);

  localparam int CMD_W = $bits(csp_pkg::cmd_t);

  logic [5:0]       pid_tab [64];
  csp_pkg::cmd_t    cmd_in;
  logic [CMD_W-1:0] cmd_vec;
  logic             q_empty;

  // requester id folded into the process range, fixed at elaboration
  for (genvar g = 0; g < 64; g++) begin : g_pid
    assign pid_tab[g] = 6'(g % MAX_PROCS);
  end

  // classify the request
  always_comb begin
    cmd_in.op          = csp_pkg::op_t'(op);
    cmd_in.sem_id      = sem_id;
    cmd_in.sid_ok      = (32'(sem_id) < NUM_SEMS);
    cmd_in.start_count = start_count;
    cmd_in.pid         = pid_tab[requester_id];
  end

  csp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (CMD_W'(cmd_in)),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_vec),
    .empty   (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = csp_pkg::cmd_t'(cmd_vec);

endmodule

### src/csp_back.sv
// ----------------------------------------------------------------------------
// csp_back
// Executes requests: slot table, counts, wait queues and the link memory.
// ----------------------------------------------------------------------------
module csp_back #(
  parameter int NUM_SEMS  = 16,
  parameter int MAX_PROCS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  csp_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output csp_pkg::res_t     res
);

  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PW = $clog2(MAX_PROCS);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_LINK = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // per-semaphore tables
  logic                     slot_used [NUM_SEMS];
  logic signed [15:0]       count     [NUM_SEMS];
  logic                     q_empty   [NUM_SEMS];
  logic [PW-1:0]            q_head    [NUM_SEMS];
  logic [PW-1:0]            q_tail    [NUM_SEMS];

  // per-process link memory: bit PW valid, low bits next id
  logic [PW:0]              link_mem  [MAX_PROCS];
  logic [PW:0]              link_rd;
  logic                     lk_we;
  logic [PW-1:0]            lk_waddr;
  logic [PW:0]              lk_wdata;
  logic                     lk_re;
  logic [PW-1:0]            lk_raddr;

  // held across multi-cycle operations
  logic [SW-1:0]            s_r;
  logic [PW-1:0]            pid_r;
  logic [PW-1:0]            h_r;

  logic [SW-1:0]            s;
  logic [PW-1:0]            pid;
  logic                     ok;
  logic signed [15:0]       cnt;
  logic signed [15:0]       p_new;
  logic signed [15:0]       v_new;
  logic                     p_block;
  logic                     v_wake;
  logic                     free_found;
  logic [SW-1:0]            free_idx;
  logic                     go;

  assign s   = SW'(cmd.sem_id);
  assign pid = PW'(cmd.pid);
  assign ok  = cmd.sid_ok && slot_used[s];
  assign cnt = count[s];
  assign go  = (state == S_RUN) && cmd_valid && !res_full;

  // saturating count updates
  assign p_new   = (cnt != csp_pkg::COUNT_MIN) ? cnt - 16'sd1 : cnt;
  assign v_new   = (cnt != csp_pkg::COUNT_MAX) ? cnt + 16'sd1 : cnt;
  assign p_block = p_new[15];
  assign v_wake  = (v_new[15] || (v_new == 16'sd0)) && !q_empty[s];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // sequencer and result formation
  always_comb begin
    state_next  = state;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    res.status  = csp_pkg::STATUS_ERR;
    lk_we       = 1'b0;
    lk_waddr    = pid;
    lk_wdata    = '0;
    lk_re       = 1'b0;
    lk_raddr    = q_head[s];
    unique case (state)
      S_RUN: begin
        if (go) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          unique case (cmd.op)
            csp_pkg::OP_ALLOC: begin
              if (free_found) begin
                res.status = csp_pkg::STATUS_OK;
                res.new_id = 4'(free_idx);
              end
            end
            csp_pkg::OP_FREE: begin
              if (ok && q_empty[s]) begin
                res.status = csp_pkg::STATUS_OK;
              end
            end
            csp_pkg::OP_WAIT: begin
              if (ok) begin
                res.status = csp_pkg::STATUS_OK;
                if (p_block) begin
                  res.blocked = 1'b1;
                  // new tail gets an empty link
                  lk_we = 1'b1;
                  if (!q_empty[s]) begin
                    state_next = S_LINK;
                  end
                end
              end
            end
            csp_pkg::OP_SIGNAL: begin
              if (ok) begin
                res.status = csp_pkg::STATUS_OK;
                if (v_wake) begin
                  // result waits for the head link
                  res_push   = 1'b0;
                  lk_re      = 1'b1;
                  state_next = S_POP;
                end
              end
            end
          endcase
        end
      end
      S_LINK: begin
        lk_we      = 1'b1;
        lk_waddr   = q_tail[s_r];
        lk_wdata   = {1'b1, pid_r};
        state_next = S_RUN;
      end
      S_POP: begin
        lk_we           = 1'b1;
        lk_waddr        = h_r;
        lk_wdata        = '0;
        res_push        = 1'b1;
        res.status      = csp_pkg::STATUS_OK;
        res.woken_valid = 1'b1;
        res.woken_id    = 6'(h_r);
        state_next      = S_RUN;
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  // operands held for the S_LINK and S_POP states
  always_ff @(posedge clk) begin
    if (go) begin
      s_r   <= s;
      pid_r <= pid;
      h_r   <= q_head[s];
    end
  end

  // slot, count and empty tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        slot_used[i] <= 1'b0;
        count[i]     <= '0;
        q_empty[i]   <= 1'b1;
      end
    end else if (go) begin
      unique case (cmd.op)
        csp_pkg::OP_ALLOC: begin
          if (free_found) begin
            slot_used[free_idx] <= 1'b1;
            count[free_idx]     <= 16'(cmd.start_count);
            q_empty[free_idx]   <= 1'b1;
          end
        end
        csp_pkg::OP_FREE: begin
          if (ok && q_empty[s]) begin
            slot_used[s] <= 1'b0;
            count[s]     <= '0;
            q_empty[s]   <= 1'b1;
          end
        end
        csp_pkg::OP_WAIT: begin
          if (ok) begin
            count[s] <= p_new;
            if (p_block) begin
              q_empty[s] <= 1'b0;
            end
          end
        end
        csp_pkg::OP_SIGNAL: begin
          if (ok) begin
            count[s] <= v_new;
          end
        end
      endcase
    end else if ((state == S_POP) && !link_rd[PW]) begin
      q_empty[s_r] <= 1'b1;
    end
  end

  // queue head and tail pointers
  always_ff @(posedge clk) begin
    if (go && (cmd.op == csp_pkg::OP_WAIT) && ok && p_block && q_empty[s]) begin
      q_head[s] <= pid;
      q_tail[s] <= pid;
    end
    if (state == S_LINK) begin
      q_tail[s_r] <= pid_r;
    end
    if ((state == S_POP) && link_rd[PW]) begin
      q_head[s_r] <= link_rd[PW-1:0];
    end
  end

  // link memory, registered read
  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (lk_re) begin
      link_rd <= link_mem[lk_raddr];
    end
  end

endmodule

### src/counting_semaphore_pool_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_pool_unit
// Pool of counting semaphores with FIFO wait queues of requester ids.
// ----------------------------------------------------------------------------
// Input side is a queue: drive op, sem_id, start_count and requester_id with
// push; the item is taken on a clock edge where push is high and full is low.
// Result side is a queue: while empty is low the oldest result is on status,
// new_id, blocked, woken_valid and woken_id; pop takes it.
// A taken item passes through the input queue and the executor into the
// output queue, whose head is on the result ports; a signal that releases a
// waiter adds the S_POP state for the registered read of the link memory.
// Throughput: one item per cycle while the output queue has room; a wait
// that appends to a non-empty queue adds the S_LINK state, set by the single
// write port of the link memory, and a signal that releases a waiter S_POP.
// Reset clears all slots to unused, counts to zero and queues to empty; both
// item queues are emptied. No clearing pass is needed.
// When the receiver does not pop, results wait in a 2-deep output queue; once
// it fills, the executor pauses and the 2-deep input queue raises full.
// ----------------------------------------------------------------------------
module counting_semaphore_pool_unit #(
  parameter int NUM_SEMS  = 16,
  parameter int MAX_PROCS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [3:0]  sem_id,
  input  logic [14:0] start_count,
  input  logic [5:0]  requester_id,
  output logic        empty,
  input  logic        pop,
  output logic        status,
  output logic [3:0]  new_id,
  output logic        blocked,
  output logic        woken_valid,
  output logic [5:0]  woken_id
);

  localparam int RES_W = $bits(csp_pkg::res_t);

  logic             cmd_valid;
  logic             cmd_pop;
  csp_pkg::cmd_t    cmd;
  logic             res_full;
  logic             res_push;
  csp_pkg::res_t    res_in;
  logic [RES_W-1:0] res_vec;
  csp_pkg::res_t    res_out;

  // accept and classify
  csp_front #(
    .NUM_SEMS  (NUM_SEMS),
    .MAX_PROCS (MAX_PROCS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .sem_id       (sem_id),
    .start_count  (start_count),
    .requester_id (requester_id),
    .cmd_pop      (cmd_pop),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  // execute
  csp_back #(
    .NUM_SEMS  (NUM_SEMS),
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue
  csp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (RES_W'(res_in)),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_vec),
    .empty   (empty)
  );

  assign res_out     = csp_pkg::res_t'(res_vec);
  assign status      = res_out.status;
  assign new_id      = res_out.new_id;
  assign blocked     = res_out.blocked;
  assign woken_valid = res_out.woken_valid;
  assign woken_id    = res_out.woken_id;

endmodule

### src/csp_chk.sv
// ----------------------------------------------------------------------------
// csp_chk
// Port-level checks of the semaphore pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "counting_semaphore_pool_unit_macros.svh"

module csp_chk (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       status,
  input logic [3:0] new_id,
  input logic       blocked,
  input logic       woken_valid,
  input logic [5:0] woken_id
);

  // the result queue comes out of reset empty and the input queue not full
  `CSP_ASSERT_IMPL(a_reset_clear, $past(rst), empty && !full, "queues not empty after reset")

  // an error result carries no other information
  `CSP_ASSERT_IMPL(a_err_clean, !empty && status,
    !blocked && !woken_valid && new_id == 4'd0 && woken_id == 6'd0, "error result not clean")

  // a request never both blocks and releases, and woken_id is zero unless one is released
  `CSP_ASSERT_IMPL(a_block_wake, !empty,
    !(blocked && woken_valid) && (woken_valid || woken_id == 6'd0), "inconsistent wake fields")

  // a waiting result holds until taken
  `CSP_ASSERT_NEXT(a_res_hold, !empty && !pop,
    !empty && $stable(status) && $stable(woken_id) && $stable(new_id), "result changed while held")

endmodule

bind counting_semaphore_pool_unit csp_chk u_csp_chk (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .status      (status),
  .new_id      (new_id),
  .blocked     (blocked),
  .woken_valid (woken_valid),
  .woken_id    (woken_id)
);

### test/counting_semaphore_pool_unit_tb.sv
// ----------------------------------------------------------------------------
// counting_semaphore_pool_unit_tb
// Self-checking bench for the semaphore pool. Items are pushed in, in some
// tests with random gaps. Each accepted item runs through a local copy of the
// pool state, which includes the counts and the linked wait queues. The
// predicted answer is then compared field by field with what the block pops
// out. Tests cover error paths, back-pressure, long random traffic, the top
// of the count range and deep wait queues.
// ----------------------------------------------------------------------------
module counting_semaphore_pool_unit_tb;

  localparam int SEMS        = 16;
  localparam int PROCS       = 64;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op = csp_pkg::OP_ALLOC;
  logic [3:0]  sem_id = '0;
  logic [14:0] start_count = '0;
  logic [5:0]  requester_id = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        status;
  logic [3:0]  new_id;
  logic        blocked;
  logic        woken_valid;
  logic [5:0]  woken_id;

  // local copy of the pool
  logic                slot_busy   [SEMS];
  logic signed [15:0]  sem_count   [SEMS];
  logic                waitq_empty [SEMS];
  logic [5:0]          waitq_head  [SEMS];
  logic [5:0]          waitq_tail  [SEMS];
  logic [6:0]          link_tab    [PROCS];

  csp_pkg::res_t owed_results[$];
  csp_pkg::res_t want;
  int   mismatches = 0;
  int   cyc = 0;
  int   rx_hold_end = 0;
  logic rx_idle_on = 1'b0;
  logic tx_idle_on = 1'b0;
  int   rx_gap = 0;

  counting_semaphore_pool_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .sem_id       (sem_id),
    .start_count  (start_count),
    .requester_id (requester_id),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .new_id       (new_id),
    .blocked      (blocked),
    .woken_valid  (woken_valid),
    .woken_id     (woken_id)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // apply one item to the local pool and return the answer it should give
  function automatic csp_pkg::res_t semaphore_step(csp_pkg::op_t o, logic [3:0] s,
                                                   logic [14:0] iv, logic [5:0] rid);
    csp_pkg::res_t r;
    logic [5:0] h;
    logic [6:0] lk;
    r = '0;
    r.status = csp_pkg::STATUS_ERR;
    case (o)
      csp_pkg::OP_ALLOC: begin
        for (int i = 0; i < SEMS; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            sem_count[i]   = $signed({1'b0, iv});
            waitq_empty[i] = 1'b1;
            r.status       = csp_pkg::STATUS_OK;
            r.new_id       = i[3:0];
            break;
          end
        end
      end
      csp_pkg::OP_FREE: begin
        if (slot_busy[s] && waitq_empty[s]) begin
          slot_busy[s] = 1'b0;
          sem_count[s] = '0;
          r.status     = csp_pkg::STATUS_OK;
        end
      end
      csp_pkg::OP_WAIT: begin
        if (slot_busy[s]) begin
          r.status = csp_pkg::STATUS_OK;
          if (sem_count[s] != csp_pkg::COUNT_MIN) sem_count[s] = sem_count[s] - 16'sd1;
          if (sem_count[s] < 0) begin
            // append requester to the tail of the wait list
            link_tab[rid] = '0;
            if (waitq_empty[s]) begin
              waitq_head[s]  = rid;
              waitq_empty[s] = 1'b0;
            end else begin
              link_tab[waitq_tail[s]] = {1'b1, rid};
            end
            waitq_tail[s] = rid;
            r.blocked = 1'b1;
          end
        end
      end
      default: begin
        if (slot_busy[s]) begin
          r.status = csp_pkg::STATUS_OK;
          if (sem_count[s] != csp_pkg::COUNT_MAX) sem_count[s] = sem_count[s] + 16'sd1;
          if (sem_count[s] <= 0 && !waitq_empty[s]) begin
            // release the head waiter
            h  = waitq_head[s];
            lk = link_tab[h];
            if (lk[6]) waitq_head[s] = lk[5:0];
            else waitq_empty[s] = 1'b1;
            link_tab[h]   = '0;
            r.woken_valid = 1'b1;
            r.woken_id    = h;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string fname, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t %s: expected %0d, got %0d", $time, fname, want_v, got_v);
    end
  endfunction

  // result check first, then predict the item taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      owed_results.delete();
      for (int i = 0; i < SEMS; i++) begin
        slot_busy[i]   = 1'b0;
        sem_count[i]   = '0;
        waitq_empty[i] = 1'b1;
        waitq_head[i]  = '0;
        waitq_tail[i]  = '0;
      end
      for (int i = 0; i < PROCS; i++) link_tab[i] = '0;
    end else begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t result: expected none, got status %0d", $time, status);
        end else begin
          want = owed_results.pop_front();
          check_field("status", 8'(want.status), 8'(status));
          check_field("new_id", 8'(want.new_id), 8'(new_id));
          check_field("blocked", 8'(want.blocked), 8'(blocked));
          check_field("woken_valid", 8'(want.woken_valid), 8'(woken_valid));
          check_field("woken_id", 8'(want.woken_id), 8'(woken_id));
        end
      end
      if (push && !full)
        owed_results.push_back(semaphore_step(csp_pkg::op_t'(op), sem_id, start_count,
                                              requester_id));
    end
  end

  // result side: long hold-off on request, otherwise random stalls while rx_idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      pop    <= 1'b0;
      rx_gap <= 0;
    end else if (cyc < rx_hold_end) begin
      pop <= 1'b0;
    end else if (rx_gap != 0) begin
      pop    <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      pop    <= 1'b0;
      rx_gap <= idle_len() - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // offer one item and hold it until the block takes it
  task automatic send_item(input csp_pkg::op_t o, input logic [3:0] s,
                           input logic [14:0] iv, input logic [5:0] rid);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    op           <= o;
    sem_id       <= s;
    start_count  <= iv;
    requester_id <= rid;
    do @(posedge clk); while (full);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // error paths, saturation at the top, queue release, duplicate waiter, full pool
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    send_item(csp_pkg::OP_ALLOC, 4'hF, 15'd0, 6'd0);
    send_item(csp_pkg::OP_ALLOC, 4'h0, 15'h7FFF, 6'h3F);
    send_item(csp_pkg::OP_SIGNAL, 4'd1, 15'd0, 6'd0);
    send_item(csp_pkg::OP_WAIT, 4'd1, 15'd0, 6'd1);
    send_item(csp_pkg::OP_WAIT, 4'd0, 15'd0, 6'h3F);
    send_item(csp_pkg::OP_FREE, 4'd0, 15'd0, 6'd0);
    send_item(csp_pkg::OP_SIGNAL, 4'd0, 15'd0, 6'd0);
    send_item(csp_pkg::OP_FREE, 4'd0, 15'd0, 6'd0);
    send_item(csp_pkg::OP_FREE, 4'd0, 15'd0, 6'd0);
    send_item(csp_pkg::OP_WAIT, 4'hF, 15'd0, 6'd2);
    send_item(csp_pkg::OP_SIGNAL, 4'd9, 15'h7FFF, 6'd3);
    // same requester queued twice breaks the list; count stays negative
    send_item(csp_pkg::OP_ALLOC, 4'd0, 15'd0, 6'd0);
    send_item(csp_pkg::OP_WAIT, 4'd0, 15'd0, 6'd5);
    send_item(csp_pkg::OP_WAIT, 4'd0, 15'd0, 6'd6);
    send_item(csp_pkg::OP_WAIT, 4'd0, 15'd0, 6'd5);
    send_item(csp_pkg::OP_SIGNAL, 4'd0, 15'd0, 6'd0);
    send_item(csp_pkg::OP_SIGNAL, 4'd0, 15'd0, 6'd0);
    // fill the pool, last allocate finds no slot
    for (int i = 0; i < 15; i++)
      send_item(csp_pkg::OP_ALLOC, 4'($urandom_range(0, 15)),
                15'($urandom_range(0, 32767)), 6'($urandom_range(0, 63)));
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    rx_hold_end <= cyc + 80;
    for (int i = 0; i < 24; i++)
      send_item($urandom_range(0, 1) ? csp_pkg::OP_WAIT : csp_pkg::OP_SIGNAL,
                4'($urandom_range(0, 15)), 15'd0, 6'($urandom_range(0, 63)));
  endtask

  // mostly traffic on live slots, some noise on random ones
  task automatic test_random_traffic(input int n);
    int m, r, pick;
    logic [3:0] sid;
    logic [14:0] iv;
    csp_pkg::op_t o;
    for (int k = 0; k < n; k++) begin
      if (k % 150 == 0) begin
        m = (k / 150) % 4;
        tx_idle_on = (m == 0 || m == 2);
        rx_idle_on <= (m == 0 || m == 1);
      end
      sid = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 8) begin
        for (int j = 0; j < SEMS; j++) begin
          pick = (sid + j) % SEMS;
          if (slot_busy[pick]) begin
            sid = 4'(pick);
            break;
          end
        end
      end
      r = $urandom_range(0, 99);
      if (r < 12) o = csp_pkg::OP_ALLOC;
      else if (r < 22) o = csp_pkg::OP_FREE;
      else if (r < 62) o = csp_pkg::OP_WAIT;
      else o = csp_pkg::OP_SIGNAL;
      case ($urandom_range(0, 9))
        0: iv = 15'($urandom_range(0, 32767));
        1: iv = 15'h7FFF;
        default: iv = 15'($urandom_range(0, 3));
      endcase
      send_item(o, sid, iv, 6'($urandom_range(0, 63)));
    end
  endtask

  // release waiters and free every slot so the deep queue test gets one
  task automatic test_clear_pool();
    int tries;
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    for (int s = 0; s < SEMS; s++) begin
      tries = 0;
      while (slot_busy[s] && !waitq_empty[s] && tries < 200) begin
        send_item(csp_pkg::OP_SIGNAL, 4'(s), 15'd0, 6'($urandom_range(0, 63)));
        wait_idle();
        tries++;
      end
      if (slot_busy[s]) begin
        send_item(csp_pkg::OP_FREE, 4'(s), 15'd0, 6'd0);
        wait_idle();
      end
    end
  endtask

  // drive one count well below zero, then signal it back up past zero
  task automatic test_deep_queue();
    logic [3:0] sid;
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    sid = '0;
    for (int s = SEMS - 1; s >= 0; s--)
      if (!slot_busy[s]) sid = 4'(s);
    send_item(csp_pkg::OP_ALLOC, 4'($urandom_range(0, 15)), 15'd0,
              6'($urandom_range(0, 63)));
    for (int k = 0; k < 40; k++)
      send_item(csp_pkg::OP_WAIT, sid, 15'd0, 6'($urandom_range(0, 63)));
    for (int k = 0; k < 42; k++)
      send_item(csp_pkg::OP_SIGNAL, sid, 15'd0, 6'd0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_idle();
    test_backpressure();
    wait_idle();
    test_random_traffic(1250);
    wait_idle();
    test_clear_pool();
    test_deep_queue();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
